// ----- hw/rtl/ipv4_fragment_tracker_macros.svh -----
// Assertion helpers for the fragment tracker RTL.
`ifndef IPV4_FRAGMENT_TRACKER_MACROS_SVH
`define IPV4_FRAGMENT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define IFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/ift_pkg.sv -----
package ift_pkg;
    localparam logic [2:0] ST_PASS  = 3'd0;
    localparam logic [2:0] ST_ERROR = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_FULL  = 3'd5;
    localparam logic [2:0] ST_TICK  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MATCH, S_ALLOC, S_SCAN_RD, S_SCAN,
        S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_CHAIN_RD, S_CHAIN,
        S_TICK, S_TICK_FIN, S_OUT
    } t_state;

    // Controller commands to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clr_idx;    // clear walk index
        logic inc_idx;    // advance walk index
        logic take_ctx;   // lock context = walk index
        logic alloc;      // write new context at walk index
        logic restart;    // restart timeout of context at walk index
        logic set_pos;    // pos = walk index
        logic init_shift; // k = n
        logic dec_k;      // k--
        logic rd_store;   // read store at walk index (or k-1 on shift)
        logic rd_shift;
        logic wr_shift;
        logic wr_new;
        logic tick_step;  // age context at walk index
        logic free_ctx;
        logic set_res;    // latch result
        logic [2:0] res_st;
        logic res_idx;    // include context index
        logic res_tot;    // include total
        logic res_exp;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic is_pass;
        logic is_err;
        logic idx_last;  // walk index at last context
        logic idx_end;   // walk index == n (fragment walk)
        logic ctx_match;
        logic ctx_free;
        logic rd_eq;     // stored offset == new offset
        logic rd_gt;
        logic list_full;
        logic k_at_pos;
        logic chain_ok;  // stored offset == running end
        logic last_is_end; // walk index == n-1
        logic rd_last;
    } t_sts;
endpackage

// ----- hw/rtl/ift_datapath.sv -----
module ift_datapath #(
    parameter int NUM_CONTEXTS = 8,
    parameter int FRAGS_PER_CONTEXT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ift_pkg::t_cmd        i_cmd,
    output ift_pkg::t_sts        o_sts,
    input  logic                 i_cfg_wr,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_req_type,
    input  logic [31:0]          i_src_addr,
    input  logic [31:0]          i_dst_addr,
    input  logic [15:0]          i_ident,
    input  logic                 i_dont_frag,
    input  logic                 i_more_frags,
    input  logic [12:0]          i_offset_units,
    input  logic [3:0]           i_header_words,
    input  logic [15:0]          i_total_len,
    input  logic [15:0]          i_avail_len,
    output logic [2:0]           o_status,
    output logic [2:0]           o_context_index,
    output logic [16:0]          o_payload_total,
    output logic [3:0]           o_expired_count
);
    import ift_pkg::*;

    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int NW = $clog2(FRAGS_PER_CONTEXT + 1);
    localparam int IW = (CW > NW) ? CW : NW;
    localparam int DEPTH = NUM_CONTEXTS * FRAGS_PER_CONTEXT;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(NUM_CONTEXTS + 1);

    logic [15:0] r_timeout;
    logic        r_type, r_df, r_mf;
    logic [31:0] r_src, r_dst;
    logic [15:0] r_id;
    logic [15:0] r_boff;
    logic [16:0] r_tlen_m, r_alen;
    logic [6:0]  r_hwb;

    logic [NUM_CONTEXTS-1:0] r_cvalid;
    logic [31:0] r_csrc [NUM_CONTEXTS];
    logic [31:0] r_cdst [NUM_CONTEXTS];
    logic [15:0] r_cid  [NUM_CONTEXTS];
    logic [15:0] r_ctime[NUM_CONTEXTS];
    logic [NW-1:0] r_ccnt [NUM_CONTEXTS];

    logic [32:0] r_mem [DEPTH];
    logic [32:0] r_rd;

    logic [IW-1:0] r_idx, r_k, r_pos;
    logic [CW-1:0] r_ctx;
    logic [NW-1:0] r_n;
    logic [16:0]   r_end;
    logic [XW-1:0] r_exp;
    logic [2:0]    r_st, r_ci;
    logic [16:0]   r_tot;
    logic [3:0]    r_ex;

    logic [CW-1:0] w_ci;
    logic [AW-1:0] w_base, w_ra, w_wa;
    logic [32:0]   w_wd;
    logic          w_we;
    logic [16:0]   w_psize;

    assign w_ci    = r_idx[CW-1:0];
    assign w_base  = AW'(r_ctx) * AW'(FRAGS_PER_CONTEXT);
    assign w_psize = r_tlen_m - 17'(r_hwb);
    assign w_ra    = i_cmd.rd_shift ? w_base + AW'(r_k - 1'b1) : w_base + AW'(r_idx);
    assign w_we    = i_cmd.wr_shift | i_cmd.wr_new;
    assign w_wa    = i_cmd.wr_new ? w_base + AW'(r_pos) : w_base + AW'(r_k);
    assign w_wd    = i_cmd.wr_new ? {~r_mf, w_psize[15:0], r_boff} : r_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (i_cmd.rd_store | i_cmd.rd_shift) r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd60;
            r_cvalid  <= '0;
            for (int i = 0; i < NUM_CONTEXTS; i++) r_ccnt[i] <= '0;
        end else begin
            if (i_cfg_wr) r_timeout <= i_cfg_data;
            if (i_cmd.alloc) begin
                r_cvalid[w_ci] <= 1'b1;
                r_csrc[w_ci]   <= r_src;
                r_cdst[w_ci]   <= r_dst;
                r_cid[w_ci]    <= r_id;
                r_ccnt[w_ci]   <= '0;
            end
            if (i_cmd.restart) r_ctime[w_ci] <= r_timeout;
            if (i_cmd.wr_new) r_ccnt[r_ctx] <= r_n + 1'b1;
            if (i_cmd.free_ctx) begin
                r_cvalid[r_ctx] <= 1'b0;
                r_ccnt[r_ctx]   <= '0;
            end
            if (i_cmd.tick_step && r_cvalid[w_ci]) begin
                if (r_ctime[w_ci] <= 16'd1) begin
                    r_cvalid[w_ci] <= 1'b0;
                    r_ccnt[w_ci]   <= '0;
                end else begin
                    r_ctime[w_ci] <= r_ctime[w_ci] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type   <= i_req_type;
            r_df     <= i_dont_frag;
            r_mf     <= i_more_frags;
            r_src    <= i_src_addr;
            r_dst    <= i_dst_addr;
            r_id     <= i_ident;
            r_boff   <= {i_offset_units, 3'b000};
            r_tlen_m <= {1'b0, i_total_len};
            r_alen   <= {1'b0, i_avail_len};
            r_hwb    <= {1'b0, i_header_words, 2'b00};
            r_exp    <= '0;
        end
        if (i_cmd.clr_idx) r_idx <= '0;
        else if (i_cmd.inc_idx) r_idx <= r_idx + 1'b1;
        if (i_cmd.take_ctx) begin
            r_ctx <= w_ci;
            r_n   <= r_ccnt[w_ci];
        end
        if (i_cmd.set_pos) r_pos <= r_idx;
        if (i_cmd.init_shift) r_k <= IW'(r_n);
        else if (i_cmd.dec_k) r_k <= r_k - 1'b1;
        if (i_cmd.wr_new) r_n <= r_n + 1'b1;
        if (i_cmd.clr_idx) r_end <= '0;
        else if (i_cmd.inc_idx) r_end <= 17'(r_rd[15:0]) + 17'(r_rd[31:16]);
        if (i_cmd.tick_step && r_cvalid[w_ci] && r_ctime[w_ci] <= 16'd1)
            r_exp <= r_exp + 1'b1;
        if (i_cmd.set_res) begin
            r_st <= i_cmd.res_st;
            r_ci <= i_cmd.res_idx ? 3'(r_ctx) : 3'd0;
            r_tot <= i_cmd.res_tot ? 17'(r_rd[15:0]) + 17'(r_rd[31:16]) : 17'd0;
            r_ex <= i_cmd.res_exp ? 4'(r_exp) : 4'd0;
        end
    end

    always_comb begin
        o_sts.is_tick    = r_type;
        o_sts.is_pass    = r_df | (~r_mf & (r_boff == 16'd0));
        o_sts.is_err     = (r_tlen_m < 17'(r_hwb)) | (r_tlen_m > r_alen);
        o_sts.idx_last   = (r_idx == IW'(NUM_CONTEXTS - 1));
        o_sts.idx_end    = (r_idx == IW'(r_n));
        o_sts.ctx_match  = r_cvalid[w_ci] && r_csrc[w_ci] == r_src &&
                           r_cdst[w_ci] == r_dst && r_cid[w_ci] == r_id;
        o_sts.ctx_free   = ~r_cvalid[w_ci];
        o_sts.rd_eq      = (r_rd[15:0] == r_boff);
        o_sts.rd_gt      = (r_rd[15:0] > r_boff);
        o_sts.list_full  = (r_n >= NW'(FRAGS_PER_CONTEXT));
        o_sts.k_at_pos   = (r_k == r_pos);
        o_sts.chain_ok   = (17'(r_rd[15:0]) == r_end);
        o_sts.last_is_end = (r_idx + 1'b1 == IW'(r_n));
        o_sts.rd_last    = r_rd[32];
    end

    assign o_status        = r_st;
    assign o_context_index = r_ci;
    assign o_payload_total = r_tot;
    assign o_expired_count = r_ex;
endmodule

// ----- hw/rtl/ift_ctrl.sv -----
`include "ipv4_fragment_tracker_macros.svh"
module ift_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output ift_pkg::t_cmd o_cmd,
    input  ift_pkg::t_sts i_sts
);
    import ift_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
    end

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_found  = r_found;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_found = 1'b0;
                if (i_sts.is_tick) n_state = S_TICK;
                else if (i_sts.is_pass) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_st = ST_PASS; n_state = S_OUT;
                end else if (i_sts.is_err) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_st = ST_ERROR; n_state = S_OUT;
                end else n_state = S_MATCH;
            end
            S_MATCH: begin
                if (i_sts.ctx_match) begin
                    o_cmd.take_ctx = 1'b1; o_cmd.restart = 1'b1;
                    o_cmd.clr_idx = 1'b1; n_state = S_SCAN_RD;
                end else if (i_sts.idx_last) begin
                    o_cmd.clr_idx = 1'b1; n_state = S_ALLOC;
                end else o_cmd.inc_idx = 1'b1;
            end
            S_ALLOC: begin
                if (i_sts.ctx_free) begin
                    o_cmd.alloc = 1'b1; o_cmd.take_ctx = 1'b1;
                    o_cmd.restart = 1'b1; o_cmd.clr_idx = 1'b1;
                    n_state = S_SCAN_RD;
                end else if (i_sts.idx_last) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_st = ST_FULL;
                    n_state = S_OUT;
                end else o_cmd.inc_idx = 1'b1;
            end
            S_SCAN_RD: begin
                if (i_sts.idx_end) begin
                    // if no larger offset was seen, append at the tail
                    o_cmd.set_pos = !r_found; n_state = S_SCAN;
                    if (i_sts.list_full) begin
                        o_cmd.set_res = 1'b1; o_cmd.res_st = ST_FULL;
                        o_cmd.res_idx = 1'b1; n_state = S_OUT;
                    end else begin
                        o_cmd.init_shift = 1'b1; n_state = S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.rd_store = 1'b1; n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.rd_eq) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_st = ST_DUP;
                    o_cmd.res_idx = 1'b1; n_state = S_OUT;
                end else if (i_sts.rd_gt && !r_found) begin
                    // first larger offset fixes the slot; keep scanning for dups
                    o_cmd.set_pos = 1'b1; n_found = 1'b1;
                    o_cmd.inc_idx = 1'b1; n_state = S_SCAN_RD;
                end else begin
                    o_cmd.inc_idx = 1'b1; n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.k_at_pos) n_state = S_INSERT;
                else begin
                    o_cmd.rd_shift = 1'b1; n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1; o_cmd.dec_k = 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_INSERT: begin
                o_cmd.wr_new = 1'b1; o_cmd.clr_idx = 1'b1;
                n_state = S_CHAIN_RD;
            end
            S_CHAIN_RD: begin
                o_cmd.rd_store = 1'b1; n_state = S_CHAIN;
            end
            S_CHAIN: begin
                if (!i_sts.chain_ok) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_st = ST_WAIT;
                    o_cmd.res_idx = 1'b1; n_state = S_OUT;
                end else if (i_sts.last_is_end) begin
                    o_cmd.set_res = 1'b1; o_cmd.res_idx = 1'b1;
                    if (i_sts.rd_last) begin
                        o_cmd.res_st = ST_DONE; o_cmd.res_tot = 1'b1;
                        o_cmd.free_ctx = 1'b1;
                    end else o_cmd.res_st = ST_WAIT;
                    n_state = S_OUT;
                end else begin
                    o_cmd.inc_idx = 1'b1; n_state = S_CHAIN_RD;
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.idx_last) n_state = S_TICK_FIN;
                else o_cmd.inc_idx = 1'b1;
            end
            S_TICK_FIN: begin
                // expired count is final once the last aging step has landed
                o_cmd.set_res = 1'b1; o_cmd.res_st = ST_TICK;
                o_cmd.res_exp = 1'b1; n_state = S_OUT;
            end
            S_OUT: begin
                // hold the result until the receiver takes the transfer
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.set_res) n_ovalid = 1'b1;
    end

    `IFT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `IFT_ASSERT_NEXT(a_out_after, i_clk, i_rst_n,
        r_state == S_OUT && !i_stall, r_state == S_IDLE)
    `IFT_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, 1'b1, r_ovalid == (r_state == S_OUT))
endmodule

// ----- hw/rtl/ipv4_fragment_tracker.sv -----
// IPv4 fragment tracker: one result per item. A tick ages every context in turn;
// a fragment goes through the context search and then the walk, shift and chain
// check over the fragment memory, one entry at a time. One item is in work at a
// time; the result holds until taken and the input stalls until then.
`include "ipv4_fragment_tracker_macros.svh"
module ipv4_fragment_tracker #(
    parameter int NUM_CONTEXTS = 8,
    parameter int FRAGS_PER_CONTEXT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_ident,
    input  logic        i_dont_frag,
    input  logic        i_more_frags,
    input  logic [12:0] i_offset_units,
    input  logic [3:0]  i_header_words,
    input  logic [15:0] i_total_len,
    input  logic [15:0] i_avail_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_context_index,
    output logic [16:0] o_payload_total,
    output logic [3:0]  o_expired_count
);
    import ift_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ift_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    ift_datapath #(
        .NUM_CONTEXTS(NUM_CONTEXTS), .FRAGS_PER_CONTEXT(FRAGS_PER_CONTEXT)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_wr(i_cfg_we), .i_cfg_data(i_cfg_wdata),
        .i_req_type, .i_src_addr, .i_dst_addr, .i_ident, .i_dont_frag,
        .i_more_frags, .i_offset_units, .i_header_words, .i_total_len,
        .i_avail_len, .o_status, .o_context_index, .o_payload_total,
        .o_expired_count
    );

    `IFT_ASSERT_IMP(a_stall_when_out, i_clk, i_rst_n, o_valid, o_stall)
    `IFT_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `IFT_ASSERT_NEXT(a_hold_status, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_status) && $stable(o_context_index) && $stable(o_payload_total))
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

typedef struct packed {
    logic        req_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident;
    logic        dont_frag;
    logic        more_frags;
    logic [12:0] offset_units;
    logic [3:0]  header_words;
    logic [15:0] total_len;
    logic [15:0] avail_len;
} frag_req_t;

typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  context_index;
    logic [16:0] payload_total;
    logic [3:0]  expired_count;
} frag_res_t;

class frag_scoreboard;
    bit [15:0] timeout_secs = 16'd60;
    bit        slot_valid [8];
    bit [31:0] slot_src [8];
    bit [31:0] slot_dst [8];
    bit [15:0] slot_ident [8];
    bit [15:0] slot_left [8];
    int        slot_count [8];
    bit [15:0] piece_off [8][16];
    bit [15:0] piece_len [8][16];
    bit        piece_last [8][16];
    frag_res_t expected_results [$];
    int        mismatches = 0;

    function frag_res_t reassemble(frag_req_t r);
        frag_res_t res;
        int c, k, n, pos, hb, expired;
        bit found;
        bit [15:0] psize, boff;
        res = '0;
        if (r.req_type) begin
            expired = 0;
            for (c = 0; c < 8; c++) begin
                if (!slot_valid[c]) continue;
                if (slot_left[c] <= 1) begin
                    slot_valid[c] = 0;
                    slot_count[c] = 0;
                    expired++;
                end else begin
                    slot_left[c]--;
                end
            end
            res.status = ift_pkg::ST_TICK;
            res.expired_count = expired[3:0];
            return res;
        end
        if (r.dont_frag || (!r.more_frags && r.offset_units == 0)) begin
            res.status = ift_pkg::ST_PASS;
            return res;
        end
        hb = r.header_words * 4;
        if (int'(r.total_len) < hb || r.total_len > r.avail_len) begin
            res.status = ift_pkg::ST_ERROR;
            return res;
        end
        psize = r.total_len - hb[15:0];
        boff = {r.offset_units, 3'b000};
        found = 0;
        for (c = 0; c < 8; c++)
            if (slot_valid[c] && slot_src[c] == r.src_addr && slot_dst[c] == r.dst_addr &&
                slot_ident[c] == r.ident) begin
                found = 1;
                break;
            end
        if (!found) begin
            for (c = 0; c < 8; c++)
                if (!slot_valid[c]) break;
            if (c >= 8) begin
                res.status = ift_pkg::ST_FULL;
                return res;
            end
            slot_valid[c] = 1;
            slot_src[c] = r.src_addr;
            slot_dst[c] = r.dst_addr;
            slot_ident[c] = r.ident;
            slot_count[c] = 0;
        end
        slot_left[c] = timeout_secs;
        res.context_index = c[2:0];
        n = slot_count[c];
        pos = n;
        for (k = 0; k < n; k++) begin
            if (piece_off[c][k] == boff) begin
                res.status = ift_pkg::ST_DUP;
                return res;
            end
            if (piece_off[c][k] > boff) begin
                pos = k;
                break;
            end
        end
        if (n >= 16) begin
            res.status = ift_pkg::ST_FULL;
            return res;
        end
        // shift the tail up to keep the list sorted by offset
        for (k = n; k > pos; k--) begin
            piece_off[c][k] = piece_off[c][k-1];
            piece_len[c][k] = piece_len[c][k-1];
            piece_last[c][k] = piece_last[c][k-1];
        end
        piece_off[c][pos] = boff;
        piece_len[c][pos] = psize;
        piece_last[c][pos] = !r.more_frags;
        n++;
        slot_count[c] = n;
        res.status = ift_pkg::ST_WAIT;
        if (piece_off[c][0] != 0) return res;
        for (k = 0; k + 1 < n; k++)
            if (17'(piece_off[c][k+1]) != 17'(piece_off[c][k]) + 17'(piece_len[c][k]))
                return res;
        if (piece_last[c][n-1]) begin
            res.status = ift_pkg::ST_DONE;
            res.payload_total = 17'(piece_off[c][n-1]) + 17'(piece_len[c][n-1]);
            slot_valid[c] = 0;
            slot_count[c] = 0;
        end
        return res;
    endfunction

    function void note_input(frag_req_t r);
        expected_results.push_back(reassemble(r));
    endfunction

    function void check_result(frag_res_t got);
        frag_res_t want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = expected_results.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected st=%0d idx=%0d tot=%0d exp=%0d, ",
                          "got st=%0d idx=%0d tot=%0d exp=%0d"},
                         want.status, want.context_index, want.payload_total,
                         want.expired_count, got.status, got.context_index,
                         got.payload_total, got.expired_count);
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int NFLOWS = 12;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid = 0;
    logic        o_stall;
    frag_req_t   drv = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [2:0]  o_context_index;
    logic [16:0] o_payload_total;
    logic [3:0]  o_expired_count;

    frag_scoreboard sb = new();
    frag_req_t stim_q [$];
    int  pushed = 0, accepted = 0, cycles = 0, long_hold = 0;
    bit  no_idle = 0;
    bit [31:0] flow_src [NFLOWS];
    bit [31:0] flow_dst [NFLOWS];
    bit [15:0] flow_id [NFLOWS];
    int        flow_chunk [NFLOWS];

    ipv4_fragment_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(drv.req_type), .i_src_addr(drv.src_addr), .i_dst_addr(drv.dst_addr),
        .i_ident(drv.ident), .i_dont_frag(drv.dont_frag), .i_more_frags(drv.more_frags),
        .i_offset_units(drv.offset_units), .i_header_words(drv.header_words),
        .i_total_len(drv.total_len), .i_avail_len(drv.avail_len),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_context_index(o_context_index),
        .o_payload_total(o_payload_total), .o_expired_count(o_expired_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ipv4_fragment_tracker] ERROR");
            $finish;
        end
    end

    // sender: one transfer per queued request
    initial begin
        frag_req_t r;
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (stim_q.size() == 0) begin
                i_valid <= 0;
                @(posedge i_clk);
            end else begin
                r = stim_q.pop_front();
                gap = no_idle ? 0 : $urandom_range(0, 17);
                if (gap > 0) begin
                    i_valid <= 0;
                    repeat (gap) @(posedge i_clk);
                end
                drv <= r;
                i_valid <= 1;
                do @(posedge i_clk); while (o_stall);
                sb.note_input(r);
                accepted++;
            end
        end
    end

    // receiver: check each transfer, then hold off a random number of cycles
    initial begin
        int hold;
        logic s;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_result({o_status, o_context_index, o_payload_total, o_expired_count});
                hold = no_idle ? 0 : $urandom_range(0, 17);
            end
            if (long_hold > 0) begin
                long_hold--;
                s = 1;
            end else if (hold > 0) begin
                hold--;
                s = 1;
            end else begin
                s = 0;
            end
            i_stall <= s;
        end
    end

    function automatic frag_req_t piece(int f, int idx, bit mf);
        frag_req_t r;
        r = '0;
        r.src_addr = flow_src[f];
        r.dst_addr = flow_dst[f];
        r.ident = flow_id[f];
        r.more_frags = mf;
        r.offset_units = 13'(idx * flow_chunk[f]);
        r.header_words = 4'd5;
        r.total_len = 16'(20 + 8 * flow_chunk[f]);
        r.avail_len = r.total_len + 16'($urandom_range(0, 100));
        return r;
    endfunction

    function automatic frag_req_t random_req();
        frag_req_t r;
        int f, sel, idx;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            r = '0;
            r.req_type = 1;
        end else if (sel < 25) begin
            r = {4'($urandom), $urandom, $urandom, $urandom, $urandom};
            r.req_type = ($urandom_range(0, 9) == 0);
        end else begin
            f = $urandom_range(0, NFLOWS - 1);
            // first two flows spread wide so their lists can fill up
            idx = (f < 2) ? $urandom_range(0, 19) : $urandom_range(0, 4);
            r = piece(f, idx, (f < 2) ? ($urandom_range(0, 19) != 0) : (idx != 3));
        end
        return r;
    endfunction

    task automatic push(frag_req_t r);
        stim_q.push_back(r);
        pushed++;
    endtask

    task automatic drain();
        while (pushed != accepted || sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_timeout(bit [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.timeout_secs = v;
    endtask

    initial begin
        frag_req_t r;
        bit [15:0] timeouts [6] = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd60, 16'd10};
        int i, ph;
        for (i = 0; i < NFLOWS; i++) begin
            flow_src[i] = (i < 6) ? 32'hC0A80001 : $urandom;
            flow_dst[i] = (i < 6) ? 32'h0A000001 : $urandom;
            flow_id[i] = (i < 6) ? 16'(i) : 16'($urandom);
            flow_chunk[i] = $urandom_range(1, 4);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: pass, errors, an out-of-order set, duplicate, tick, table full
        r = '1; r.req_type = 0; push(r);
        r = '0; push(r);
        r = piece(0, 1, 1); r.header_words = 4'd15; r.total_len = 16'd59; push(r);
        r = piece(0, 1, 1); r.avail_len = r.total_len - 1; push(r);
        flow_chunk[0] = 1;
        push(piece(0, 2, 0));
        push(piece(0, 0, 1));
        push(piece(0, 0, 1));
        push(piece(0, 1, 1));
        r = '0; r.req_type = 1; push(r);
        for (i = 1; i <= 9; i++) push(piece(i, 1, 1));
        r = piece(0, 4, 1); r.offset_units = 13'h1fff; push(r);
        r = '0; r.req_type = 1; push(r);
        drain();

        write_timeout(16'd0);
        r = '0; r.req_type = 1; push(r);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            write_timeout(timeouts[ph]);
            no_idle = (ph == 4);
            if (ph == 2) long_hold = 400;
            for (i = 0; i < 170; i++) push(random_req());
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("[ipv4_fragment_tracker] OK");
        else
            $display("[ipv4_fragment_tracker] ERROR");
        $finish;
    end
endmodule
